FILE: design/ibdr_pkg.sv
`timescale 1ns / 1ps
package ibdr_pkg;

  localparam int DEF_MAX_WIDTH = 1024;

  localparam int FW_W = 11;
  localparam int FH_W = 16;
  localparam int ROW_W = FH_W + 1;

  localparam int DEF_FRAME_WIDTH = 640;
  localparam int DEF_FRAME_HEIGHT = 480;
  localparam int MIN_DIM = 5;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // 5x5 window, four older rows held per column in the line store
  localparam int WIN = 5;
  localparam int LINE_BITS = WIN - 1;
  localparam int FIRST_CENTER_COL = WIN - 1;
  localparam int LAG = 3;
  localparam int SKIP_W = 2;
  localparam logic [SKIP_W-1:0] SKIP_AFTER_BLACK = 2'd2;

  typedef struct packed {
    logic is_pixel;
    logic visit;
    logic col_first;
    logic emit;
    logic last;
    logic pixel;
  } ibdr_op_t;

endpackage

FILE: design/ibdr_if.sv
`timescale 1ns / 1ps
interface ibdr_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic pixel_white;
  modport source(output valid, mode, pixel_white, input ready);
  modport sink(input valid, mode, pixel_white, output ready);
endinterface

interface ibdr_out_if;
  logic valid;
  logic ready;
  logic pixel_white_out;
  logic last_pixel;
  modport source(output valid, pixel_white_out, last_pixel, input ready);
  modport sink(input valid, pixel_white_out, last_pixel, output ready);
endinterface

interface ibdr_cfg_if;
  import ibdr_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: design/ibdr_ctrl.sv
`timescale 1ns / 1ps
module ibdr_ctrl #(
  parameter int MAX_WIDTH = ibdr_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  ibdr_in_if.sink                           pix_in,
  ibdr_cfg_if.sink                          cfg,
  input  logic                              advance,
  output logic                              stage_valid,
  output ibdr_pkg::ibdr_op_t                op,
  output logic                              rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
  output logic [$clog2(MAX_WIDTH)-1:0]      wb_addr
);
  import ibdr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = CW + 1;
  localparam int PW = EW + FH_W;
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [EW-1:0]    eff_width;
  logic [FH_W-1:0]  eff_height;
  logic [PW-1:0]    frame_size;
  logic [31:0]      width_wide;
  logic [FH_W-1:0]  height_clamped;
  logic [1:0]       settle;

  logic [CW-1:0]    in_column;
  logic [ROW_W-1:0] in_row;
  logic [PW-1:0]    out_position;

  logic             in_accept;
  logic             cfg_write;
  logic             row_done;
  logic             is_pixel;
  logic             drain;
  logic             active;
  logic             emit;
  logic             last;
  logic [EW-1:0]    col_inc;
  logic [EW-1:0]    wb_wide;
  logic [PW-1:0]    pos_inc;
  ibdr_op_t         op_next;

  always_comb begin
    width_wide = 32'(frame_width);
    if (width_wide < 32'(MIN_DIM)) begin
      width_wide = 32'(MIN_DIM);
    end else if (width_wide > 32'(MAX_WIDTH)) begin
      width_wide = 32'(MAX_WIDTH);
    end
    height_clamped = (frame_height < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : frame_height;
  end

  always_ff @(posedge clk) begin
    eff_width  <= width_wide[EW-1:0];
    eff_height <= height_clamped;
    frame_size <= PW'(eff_width) * PW'(eff_height);
  end

  // input waits until the derived frame sizes have caught up
  assign cfg.ready    = 1'b1;
  assign cfg_write    = cfg.valid && cfg.ready &&
                        (cfg.index == REG_FRAME_WIDTH || cfg.index == REG_FRAME_HEIGHT);
  assign pix_in.ready = (!stage_valid || advance) && (settle == '0);
  assign in_accept    = pix_in.valid && pix_in.ready;

  always_comb begin
    row_done  = in_row >= ROW_W'(eff_height);
    is_pixel  = !pix_in.mode && !row_done;
    drain     = row_done && (out_position < frame_size);
    active    = is_pixel || drain;
    emit      = drain || (is_pixel && ((in_row > ROW_W'(LAG)) ||
                (in_row == ROW_W'(LAG) && in_column >= CW'(LAG))));
    pos_inc   = out_position + PW'(1);
    last      = pos_inc == frame_size;
    col_inc   = EW'(in_column) + EW'(1);
    if (in_column >= CW'(LAG)) begin
      wb_wide = EW'(in_column) - EW'(LAG);
    end else begin
      wb_wide = EW'(in_column) + eff_width - EW'(LAG);
    end
    op_next.is_pixel  = is_pixel;
    op_next.visit     = is_pixel && in_row >= ROW_W'(FIRST_CENTER_COL) &&
                        in_column >= CW'(FIRST_CENTER_COL);
    op_next.col_first = in_column == CW'(FIRST_CENTER_COL);
    op_next.emit      = emit;
    op_next.last      = last;
    op_next.pixel     = pix_in.pixel_white && is_pixel;
  end

  assign rd_en   = in_accept;
  assign rd_addr = in_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(DEF_FRAME_WIDTH);
      frame_height <= FH_W'(DEF_FRAME_HEIGHT);
      in_column    <= '0;
      in_row       <= '0;
      out_position <= '0;
      stage_valid  <= 1'b0;
      settle       <= SETTLE_CYCLES;
    end else begin
      if (cfg.valid && cfg.ready && cfg.index == REG_FRAME_WIDTH) begin
        frame_width <= cfg.data[FW_W-1:0];
      end
      if (cfg.valid && cfg.ready && cfg.index == REG_FRAME_HEIGHT) begin
        frame_height <= cfg.data[FH_W-1:0];
      end
      if (cfg_write) begin
        settle <= SETTLE_CYCLES;
      end else if (settle != '0) begin
        settle <= settle - 2'd1;
      end
      if (in_accept) begin
        stage_valid <= active;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (cfg_write) begin
        in_column    <= '0;
        in_row       <= '0;
        out_position <= '0;
      end else if (in_accept && active) begin
        if (emit && last) begin
          in_column    <= '0;
          in_row       <= '0;
          out_position <= '0;
        end else begin
          if (col_inc == eff_width) begin
            in_column <= '0;
            in_row    <= in_row + ROW_W'(1);
          end else begin
            in_column <= col_inc[CW-1:0];
          end
          if (emit) begin
            out_position <= pos_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op      <= op_next;
      wb_addr <= wb_wide[CW-1:0];
    end
  end

endmodule

FILE: design/ibdr_core.sv
`timescale 1ns / 1ps
module ibdr_core #(
  parameter int MAX_WIDTH = ibdr_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         stage_valid,
  input  ibdr_pkg::ibdr_op_t           op,
  input  logic [$clog2(MAX_WIDTH)-1:0] wb_addr,
  output logic                         advance,
  ibdr_out_if.source                   pix_out
);
  import ibdr_pkg::*;

  logic [LINE_BITS-1:0] line_mem [MAX_WIDTH];
  logic [LINE_BITS-1:0] line_rd;

  // window[col][row]: col 0 oldest, row 0 topmost
  logic [WIN-1:0]    window      [WIN];
  logic [WIN-1:0]    shifted     [WIN];
  logic [WIN-1:0]    window_next [WIN];
  logic [SKIP_W-1:0] skip_count;
  logic [SKIP_W-1:0] skip_next;
  logic              ring_white;
  logic              center_black;
  logic              commit;

  assign advance = !pix_out.valid || pix_out.ready;
  assign commit  = stage_valid && advance;

  always_comb begin
    for (int k = 0; k < WIN - 1; k++) begin
      shifted[k] = window[k + 1];
    end
    shifted[WIN-1] = {op.pixel, line_rd};

    ring_white = (&shifted[0]) && (&shifted[WIN-1]);
    for (int k = 1; k < WIN - 1; k++) begin
      ring_white = ring_white && shifted[k][0] && shifted[k][WIN-1];
    end
    center_black = !shifted[2][2];

    window_next = shifted;
    skip_next   = skip_count;
    if (op.visit) begin
      if (op.col_first || skip_count == '0) begin
        skip_next = center_black ? SKIP_AFTER_BLACK : '0;
        if (center_black && ring_white) begin
          for (int k = 1; k < WIN - 1; k++) begin
            window_next[k][WIN-2:1] = '1;
          end
        end
      end else begin
        skip_next = skip_count - SKIP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      line_rd <= line_mem[rd_addr];
    end
    if (commit) begin
      line_mem[wb_addr] <= window_next[1][WIN-1:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WIN; k++) begin
        window[k] <= '0;
      end
      skip_count    <= '0;
      pix_out.valid <= 1'b0;
    end else begin
      if (commit) begin
        window     <= window_next;
        skip_count <= skip_next;
      end
      if (advance) begin
        pix_out.valid <= commit && op.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && op.emit) begin
      pix_out.pixel_white_out <= window_next[1][1];
      pix_out.last_pixel      <= op.last;
    end
  end

endmodule

FILE: design/isolated_black_dot_remover.sv
`timescale 1ns / 1ps
// Pepper-noise removal on a binary mask with a 5x5 window. Pixels enter in
// raster order, one item per cycle sustained while the output is not
// stalled; each item passes an input register and the window logic into
// the output register. Output lags the input by 3*width+3 positions: once a
// frame's pixels are in, send one flush item per remaining pixel. A single
// line store of MAX_WIDTH words, four bits wide, holds the older rows, read
// once and written once per item. Width and height may only be written
// while the block is idle; a write restarts the frame, and the input is held
// off after reset or after a width or height write until the derived frame
// sizes have settled.
module isolated_black_dot_remover #(
  parameter int MAX_WIDTH = ibdr_pkg::DEF_MAX_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  ibdr_in_if.sink    pix_in,
  ibdr_out_if.source pix_out,
  ibdr_cfg_if.sink   cfg
);
  import ibdr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic          advance;
  logic          stage_valid;
  ibdr_op_t      op;
  logic          rd_en;
  logic [CW-1:0] rd_addr;
  logic [CW-1:0] wb_addr;

  ibdr_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .pix_in     (pix_in),
    .cfg        (cfg),
    .advance    (advance),
    .stage_valid(stage_valid),
    .op         (op),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .wb_addr    (wb_addr)
  );

  ibdr_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .stage_valid(stage_valid),
    .op         (op),
    .wb_addr    (wb_addr),
    .advance    (advance),
    .pix_out    (pix_out)
  );

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |-> !pix_in.ready)
    else $error("item accepted over a stalled stage");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && advance && op.emit) |=> pix_out.valid)
    else $error("emitting item lost");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && advance && !op.emit) |=> !pix_out.valid)
    else $error("result without emitting item");

  a_visit_pixel: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && op.visit) |-> op.is_pixel)
    else $error("window visit on a flush item");

endmodule
